>>> hw/rtl/frame_rate_meter_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the frame rate meter checker
// Immediate-implication and next-cycle-implication forms, clocked on aclk
// and held off while aresetn is low.
// ---------------------------------------------------------------------------
`ifndef FRAME_RATE_METER_TOP_ASSERT_SVH
`define FRAME_RATE_METER_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define FRM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define FRM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/frm_pkg.sv
// ---------------------------------------------------------------------------
// Frame rate meter package
// Shared widths, constants, state types and the rate unit interface.
// ---------------------------------------------------------------------------
package frm_pkg;

    localparam int TS_W    = 64;
    localparam int WLEN_W  = 24;
    localparam int CNT_W   = 32;
    localparam int RATE_W  = 16;
    localparam int SCALE_W = 24;
    localparam int PROD_W  = CNT_W + SCALE_W;

    localparam logic [SCALE_W-1:0] RATE_SCALE   = 24'd10000000;
    localparam logic [WLEN_W-1:0]  WINDOW_RESET = 24'd500000;
    localparam logic [RATE_W-1:0]  RATE_MAX     = 16'hFFFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_CHECK,
        ST_WAIT,
        ST_DONE
    } frm_state_t;

    typedef enum logic [1:0] {
        U_IDLE,
        U_MUL,
        U_SAT,
        U_DIV
    } frm_unit_state_t;

    typedef struct packed {
        logic              start;
        logic [CNT_W-1:0]  frames;
        logic [TS_W-1:0]   elapsed;
    } frm_unit_req_t;

    typedef struct packed {
        logic              done;
        logic [RATE_W-1:0] rate;
    } frm_unit_rsp_t;

endpackage

>>> hw/rtl/frame_rate_meter_top.sv
// ---------------------------------------------------------------------------
// Frame rate meter
// Windowed frame rate measurement in tenths of a frame per second.
// ---------------------------------------------------------------------------
// One item is handled at a time. A restart item, or a tick that does not
// close the window, goes from ST_EVAL (and ST_CHECK, for a tick that
// advances the window) to ST_DONE, which loads its result. A tick that
// closes the window runs the rate unit: 24 bit-serial multiply steps by
// 10^7, one saturation compare and, if not saturated, 16 restoring
// division steps. The result sits in an output register, so the next
// item can be taken while a result waits for m_ready.
module frame_rate_meter_top
    import frm_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_op,
    input  logic [TS_W-1:0]     s_timestamp_us,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [RATE_W-1:0]   m_rate_tenths,
    output logic                m_rate_changed,
    output logic [CNT_W-1:0]    m_frame_total,
    input  logic                cfg_wr_en,
    input  logic [WLEN_W-1:0]   cfg_wr_data
);

    frm_state_t          state_reg, state_next;
    logic [WLEN_W-1:0]   wlen_reg;
    logic [TS_W-1:0]     ws_reg, ws_next;
    logic [CNT_W-1:0]    fw_reg, fw_next;
    logic [RATE_W-1:0]   last_rate_reg, last_rate_next;
    logic [CNT_W-1:0]    total_reg, total_next;
    logic                changed_reg, changed_next;
    logic                op_reg, op_next;
    logic [TS_W-1:0]     ts_reg, ts_next;
    logic [TS_W-1:0]     elapsed_reg, elapsed_next;

    logic                m_valid_reg, m_valid_next;
    logic [RATE_W-1:0]   m_rate_reg, m_rate_next;
    logic                m_changed_reg, m_changed_next;
    logic [CNT_W-1:0]    m_total_reg, m_total_next;

    logic [TS_W:0]       diff;
    frm_unit_req_t       unit_req;
    frm_unit_rsp_t       unit_rsp;

    frm_rate_unit u_rate (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (unit_req),
        .rsp     (unit_rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            wlen_reg      <= WINDOW_RESET;
            ws_reg        <= '0;
            fw_reg        <= '0;
            last_rate_reg <= '0;
            total_reg     <= CNT_W'(1);
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ws_reg        <= ws_next;
            fw_reg        <= fw_next;
            last_rate_reg <= last_rate_next;
            total_reg     <= total_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_wr_en) begin
                wlen_reg <= cfg_wr_data;
            end
        end
        changed_reg   <= changed_next;
        op_reg        <= op_next;
        ts_reg        <= ts_next;
        elapsed_reg   <= elapsed_next;
        m_rate_reg    <= m_rate_next;
        m_changed_reg <= m_changed_next;
        m_total_reg   <= m_total_next;
    end

    // borrow out of the subtract tells whether the timestamp went backward
    assign diff = {1'b0, ts_reg} - {1'b0, ws_reg};

    always_comb begin
        state_next     = state_reg;
        ws_next        = ws_reg;
        fw_next        = fw_reg;
        last_rate_next = last_rate_reg;
        total_next     = total_reg;
        changed_next   = changed_reg;
        op_next        = op_reg;
        ts_next        = ts_reg;
        elapsed_next   = elapsed_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_rate_next    = m_rate_reg;
        m_changed_next = m_changed_reg;
        m_total_next   = m_total_reg;

        unit_req.start   = 1'b0;
        unit_req.frames  = fw_reg;
        unit_req.elapsed = elapsed_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op_next    = s_op;
                    ts_next    = s_timestamp_us;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                changed_next = 1'b0;
                state_next   = ST_DONE;
                if (op_reg) begin
                    ws_next      = '0;
                    fw_next      = '0;
                    changed_next = 1'b1;
                end else begin
                    total_next = total_reg + CNT_W'(1);
                    if (ws_reg == '0) begin
                        ws_next = ts_reg;
                    end else if (!diff[TS_W] && (diff[TS_W-1:0] != '0)) begin
                        elapsed_next = diff[TS_W-1:0];
                        fw_next      = fw_reg + CNT_W'(1);
                        state_next   = ST_CHECK;
                    end else begin
                        ws_next = ts_reg;
                        fw_next = '0;
                    end
                end
            end
            ST_CHECK: begin
                if (elapsed_reg >= {{(TS_W-WLEN_W){1'b0}}, wlen_reg}) begin
                    unit_req.start = 1'b1;
                    ws_next        = ts_reg;
                    fw_next        = '0;
                    changed_next   = 1'b1;
                    state_next     = ST_WAIT;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_WAIT: begin
                if (unit_rsp.done) begin
                    last_rate_next = unit_rsp.rate;
                    state_next     = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_rate_next    = last_rate_reg;
                    m_changed_next = changed_reg;
                    m_total_next   = total_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_rate_tenths  = m_rate_reg;
    assign m_rate_changed = m_changed_reg;
    assign m_frame_total  = m_total_reg;

endmodule

>>> hw/rtl/frm_rate_unit.sv
// ---------------------------------------------------------------------------
// Frame rate unit
// Computes min(frames * 10^7 / elapsed, 65535) with a bit-serial multiply,
// a saturation check and, if unsaturated, a 16-step restoring division.
// ---------------------------------------------------------------------------
module frm_rate_unit
    import frm_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  frm_unit_req_t req,
    output frm_unit_rsp_t rsp
);

    frm_unit_state_t     state_reg, state_next;
    logic [PROD_W-1:0]   acc_reg, acc_next;
    logic [CNT_W-1:0]    mcand_reg, mcand_next;
    logic [TS_W-1:0]     den_reg, den_next;
    logic [TS_W-1:0]     rem_reg, rem_next;
    logic [RATE_W-1:0]   lo_reg, lo_next;
    logic [RATE_W-1:0]   quo_reg, quo_next;
    logic [4:0]          cnt_reg, cnt_next;
    logic                done_reg, done_next;
    logic [RATE_W-1:0]   rate_reg, rate_next;

    logic [TS_W:0]       trial;
    logic                qbit;
    logic [PROD_W-1:0]   addend;
    logic [TS_W-1:0]     num_hi;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= U_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        acc_reg   <= acc_next;
        mcand_reg <= mcand_next;
        den_reg   <= den_next;
        rem_reg   <= rem_next;
        lo_reg    <= lo_next;
        quo_reg   <= quo_next;
        cnt_reg   <= cnt_next;
        rate_reg  <= rate_next;
    end

    always_comb begin
        state_next = state_reg;
        acc_next   = acc_reg;
        mcand_next = mcand_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        lo_next    = lo_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        rate_next  = rate_reg;

        addend = RATE_SCALE[cnt_reg] ? {{SCALE_W{1'b0}}, mcand_reg} : '0;
        num_hi = {{(TS_W-PROD_W+RATE_W){1'b0}}, acc_reg[PROD_W-1:RATE_W]};
        trial  = {rem_reg, lo_reg[RATE_W-1]};
        qbit   = (trial >= {1'b0, den_reg});

        case (state_reg)
            U_IDLE: begin
                if (req.start) begin
                    acc_next   = '0;
                    mcand_next = req.frames;
                    den_next   = req.elapsed;
                    cnt_next   = 5'(SCALE_W - 1);
                    state_next = U_MUL;
                end
            end
            U_MUL: begin
                // MSB-first shift-add over the scale constant
                acc_next = {acc_reg[PROD_W-2:0], 1'b0} + addend;
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0) begin
                    state_next = U_SAT;
                end
            end
            U_SAT: begin
                // quotient >= 2^16 exactly when the upper numerator bits reach den
                if (num_hi >= den_reg) begin
                    rate_next  = RATE_MAX;
                    done_next  = 1'b1;
                    state_next = U_IDLE;
                end else begin
                    rem_next   = num_hi;
                    lo_next    = acc_reg[RATE_W-1:0];
                    quo_next   = '0;
                    cnt_next   = 5'(RATE_W - 1);
                    state_next = U_DIV;
                end
            end
            U_DIV: begin
                if (qbit) begin
                    rem_next = TS_W'(trial - {1'b0, den_reg});
                end else begin
                    rem_next = trial[TS_W-1:0];
                end
                lo_next  = {lo_reg[RATE_W-2:0], 1'b0};
                quo_next = {quo_reg[RATE_W-2:0], qbit};
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0) begin
                    rate_next  = {quo_reg[RATE_W-2:0], qbit};
                    done_next  = 1'b1;
                    state_next = U_IDLE;
                end
            end
            default: begin
                state_next = U_IDLE;
            end
        endcase
    end

    assign rsp.done = done_reg;
    assign rsp.rate = rate_reg;

endmodule

>>> hw/rtl/frm_checker.sv
// ---------------------------------------------------------------------------
// Frame rate meter checker
// Port-level assertions on the input and result streams, bound to the top level.
// ---------------------------------------------------------------------------
`include "frame_rate_meter_top_assert.svh"

module frm_checker
    import frm_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input logic [RATE_W-1:0]   m_rate_tenths,
    input logic                m_rate_changed,
    input logic [CNT_W-1:0]    m_frame_total
);

    logic [CNT_W-1:0]  exp_total_reg;
    logic [RATE_W-1:0] exp_rate_reg;

    // last delivered total and rate
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_total_reg <= CNT_W'(1);
            exp_rate_reg  <= '0;
        end else if (m_valid && m_ready) begin
            exp_total_reg <= m_frame_total;
            exp_rate_reg  <= m_rate_tenths;
        end
    end

    `FRM_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_frame_total) && $stable(m_rate_tenths) && $stable(m_rate_changed), "result changed while stalled")

    `FRM_ASSERT_NEXT(a_one_item, s_valid && s_ready, !s_ready, "second item taken while busy")

    `FRM_ASSERT_NOW(a_total_step, m_valid && m_ready, (m_frame_total == exp_total_reg) || (m_frame_total == exp_total_reg + CNT_W'(1)), "frame total stepped by more than one")

    `FRM_ASSERT_NOW(a_rate_kept, m_valid && m_ready && !m_rate_changed, m_rate_tenths == exp_rate_reg, "rate moved without change flag")

endmodule

bind frame_rate_meter_top frm_checker u_frm_checker (.*);
